// ===== hw/rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Field widths, register indexes, reset values and state encodings.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int TRIG_W     = 8;
  localparam int CNT_W      = 4;
  localparam int GAP_W      = 17;
  localparam int TPC_W      = 8;
  localparam int DIST_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DEN_W      = CNT_W + TPC_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM  = 2'd3;

  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd20;
  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST  = 4'd5;
  localparam logic [GAP_W-1:0]  GAP_TICKS_RST     = 17'd50000;
  localparam logic [TPC_W-1:0]  TICKS_PER_CM_RST  = 8'd58;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_MEAS = 5'b01000,
    PH_GAP  = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    CTL_RUN = 2'b01,
    CTL_DIV = 2'b10
  } ctl_t;

endpackage

// ===== hw/rtl/uer_div.sv =====
// ----------------------------------------------------------------------------
// uer_div: serial restoring divider
// One quotient bit per cycle from a single shared compare and subtract unit.
// ----------------------------------------------------------------------------
module uer_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    trial;
  logic              fits;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    fits     = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], fits};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: ranging controller for a pulse-echo sensor
// Drives the trigger, times the echo and reports the averaged distance.
// ----------------------------------------------------------------------------
// Each input word is one microsecond tick carrying a start request and the
// sampled echo level. Each accepted word yields exactly one output word with
// the trigger level for that tick, the busy flag, a result flag and the most
// recent averaged distance in sixteenths of a centimeter.
// An ordinary tick's output word is held in an output register, so a new word
// is taken in the cycle the last one leaves.
// The tick that ends the last echo of a round starts a serial divider that
// produces one quotient bit per cycle; that word is registered when the
// divider finishes, and no input is taken until that word leaves.
// Configuration words are taken at any time on the cfg channel, which is
// always ready; they should be written while the block is idle.
// Reset returns the registers to their defaults, the round to idle and the
// reported distance to zero. A stalled receiver holds the output word and
// blocks further input until that word is taken.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int MAX_SAMPLES     = 8,
  parameter int ECHO_WIDTH_BITS = 16,
  parameter int FRACTION_BITS   = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_start_req,
  input  logic                              in_echo_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_trigger_level,
  output logic                              out_busy_res,
  output logic                              out_result_valid,
  output logic [uer_pkg::DIST_W-1:0]        out_distance_sixteenths,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int EW    = ECHO_WIDTH_BITS;
  localparam int SUM_W = EW + $clog2(MAX_SAMPLES);
  localparam int NUM_W = SUM_W + FRACTION_BITS;
  localparam int QX_W  = (NUM_W > uer_pkg::DIST_W) ? NUM_W : uer_pkg::DIST_W;
  localparam int EFF_W = uer_pkg::CNT_W + 1;

  logic [uer_pkg::TRIG_W-1:0] trig_ticks_r;
  logic [uer_pkg::CNT_W-1:0]  sample_count_r;
  logic [uer_pkg::GAP_W-1:0]  gap_ticks_r;
  logic [uer_pkg::TPC_W-1:0]  tpc_r;

  uer_pkg::phase_t             phase_r, phase_nxt;
  uer_pkg::ctl_t               ctl_r;
  logic [uer_pkg::GAP_W-1:0]   tick_r, tick_nxt;
  logic [EW-1:0]               echo_w_r, echo_w_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [uer_pkg::CNT_W-1:0]   taken_r, taken_nxt;
  logic [uer_pkg::DIST_W-1:0]  last_dist_r;

  logic                        out_valid_r;
  logic                        out_trig_r;
  logic                        out_busy_r;
  logic                        out_res_r;
  logic [uer_pkg::DIST_W-1:0]  out_dist_r;

  logic                        accept;
  logic                        trig;
  logic                        fin;
  logic [uer_pkg::TRIG_W-1:0]  limit;
  logic [uer_pkg::TPC_W-1:0]   tpc_eff;
  logic [EFF_W-1:0]            eff;
  logic [uer_pkg::DEN_W-1:0]   den;
  logic [NUM_W-1:0]            num;
  logic                        div_done;
  logic [NUM_W-1:0]            quot;
  logic [QX_W-1:0]             q_ext;
  logic [uer_pkg::DIST_W-1:0]  avg_dist;

  assign limit   = (trig_ticks_r == '0) ? uer_pkg::TRIG_W'(1) : trig_ticks_r;
  assign tpc_eff = (tpc_r == '0) ? uer_pkg::TPC_W'(1) : tpc_r;

  always_comb begin
    if (sample_count_r == '0) begin
      eff = EFF_W'(1);
    end else if (EFF_W'(sample_count_r) > EFF_W'(MAX_SAMPLES)) begin
      eff = EFF_W'(MAX_SAMPLES);
    end else begin
      eff = EFF_W'(sample_count_r);
    end
  end

  assign den = uer_pkg::DEN_W'(eff) * uer_pkg::DEN_W'(tpc_eff);

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    echo_w_nxt = echo_w_r;
    sum_nxt    = sum_r;
    taken_nxt  = taken_r;
    trig       = 1'b0;
    fin        = 1'b0;
    case (phase_r)
      uer_pkg::PH_IDLE: begin
        if (in_start_req) begin
          sum_nxt   = '0;
          taken_nxt = '0;
          tick_nxt  = uer_pkg::GAP_W'(1);
          trig      = 1'b1;
          phase_nxt = (limit == uer_pkg::TRIG_W'(1)) ? uer_pkg::PH_WAIT : uer_pkg::PH_TRIG;
        end
      end
      uer_pkg::PH_TRIG: begin
        trig     = 1'b1;
        tick_nxt = tick_r + 1'b1;
        if (tick_nxt >= uer_pkg::GAP_W'(limit)) begin
          phase_nxt = uer_pkg::PH_WAIT;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (in_echo_level) begin
          echo_w_nxt = EW'(1);
          phase_nxt  = uer_pkg::PH_MEAS;
        end
      end
      uer_pkg::PH_MEAS: begin
        if (in_echo_level) begin
          if (echo_w_r != '1) begin
            echo_w_nxt = echo_w_r + 1'b1;
          end
        end else begin
          sum_nxt   = sum_r + SUM_W'(echo_w_r);
          taken_nxt = taken_r + 1'b1;
          tick_nxt  = '0;
          if ((EFF_W'(taken_r) + 1'b1) >= eff) begin
            fin       = 1'b1;
            phase_nxt = uer_pkg::PH_IDLE;
          end else begin
            phase_nxt = uer_pkg::PH_GAP;
          end
        end
      end
      uer_pkg::PH_GAP: begin
        if (tick_r >= gap_ticks_r) begin
          tick_nxt  = uer_pkg::GAP_W'(1);
          trig      = 1'b1;
          phase_nxt = (limit == uer_pkg::TRIG_W'(1)) ? uer_pkg::PH_WAIT : uer_pkg::PH_TRIG;
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = uer_pkg::PH_IDLE;
      end
    endcase
  end

  assign num = NUM_W'(sum_nxt) << FRACTION_BITS;

  uer_div #(
    .NUM_W(NUM_W),
    .DEN_W(uer_pkg::DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(accept && fin),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (quot)
  );

  assign q_ext    = QX_W'(quot);
  assign avg_dist = (q_ext > QX_W'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                        : q_ext[uer_pkg::DIST_W-1:0];

  assign in_ready = (ctl_r == uer_pkg::CTL_RUN) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r   <= uer_pkg::TRIGGER_TICKS_RST;
      sample_count_r <= uer_pkg::SAMPLE_COUNT_RST;
      gap_ticks_r    <= uer_pkg::GAP_TICKS_RST;
      tpc_r          <= uer_pkg::TICKS_PER_CM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        uer_pkg::CFG_TRIGGER_TICKS: trig_ticks_r   <= cfg_data[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_SAMPLE_COUNT:  sample_count_r <= cfg_data[uer_pkg::CNT_W-1:0];
        uer_pkg::CFG_GAP_TICKS:     gap_ticks_r    <= cfg_data[uer_pkg::GAP_W-1:0];
        uer_pkg::CFG_TICKS_PER_CM:  tpc_r          <= cfg_data[uer_pkg::TPC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= uer_pkg::PH_IDLE;
      ctl_r       <= uer_pkg::CTL_RUN;
      tick_r      <= '0;
      echo_w_r    <= '0;
      sum_r       <= '0;
      taken_r     <= '0;
      last_dist_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        tick_r   <= tick_nxt;
        echo_w_r <= echo_w_nxt;
        sum_r    <= sum_nxt;
        taken_r  <= taken_nxt;
        if (fin) begin
          ctl_r       <= uer_pkg::CTL_DIV;
          out_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (div_done) begin
        ctl_r       <= uer_pkg::CTL_RUN;
        last_dist_r <= avg_dist;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !fin) begin
      out_trig_r <= trig;
      out_busy_r <= (phase_nxt != uer_pkg::PH_IDLE);
      out_res_r  <= 1'b0;
      out_dist_r <= last_dist_r;
    end else if (div_done) begin
      out_trig_r <= 1'b0;
      out_busy_r <= 1'b0;
      out_res_r  <= 1'b1;
      out_dist_r <= avg_dist;
    end
  end

  assign cfg_ready               = 1'b1;
  assign out_valid               = out_valid_r;
  assign out_trigger_level       = out_trig_r;
  assign out_busy_res            = out_busy_r;
  assign out_result_valid        = out_res_r;
  assign out_distance_sixteenths = out_dist_r;

  a_no_input_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == uer_pkg::CTL_DIV) |-> !in_ready)
    else $error("input taken while the divider runs");

  a_result_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |=> (out_valid && out_result_valid && (phase_r == uer_pkg::PH_IDLE)))
    else $error("divider finish did not present a result");

  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_valid) |-> !out_busy_res)
    else $error("result word reports busy");

  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trigger_level) |-> out_busy_res)
    else $error("trigger driven outside a round");

  a_no_output_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == uer_pkg::CTL_DIV) |-> !out_valid)
    else $error("output word pending while dividing");

endmodule
